// ===== rtl/core/tgpg_pkg.sv =====
// Shared types, constants and helpers of the tiled grid permutation generator.
`default_nettype none

package tgpg_pkg;

   // Width of one axis register and of the positions on the result channel.
   localparam int CFG_W  = 9;
   localparam int POS_W  = 26;
   localparam int COMP_W = 2;

   // Default clamp for every axis register.
   localparam int MAX_CELLS_DEFAULT = 256;

   // Last component index when each cell expands into three entries.
   localparam logic [COMP_W-1:0] COMP_LAST = 2'd2;

   // Cycles after a register write before the stride products are usable.
   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      CSR_CELLS_X    = 3'd0,
      CSR_CELLS_Y    = 3'd1,
      CSR_CELLS_Z    = 3'd2,
      CSR_TILE_X     = 3'd3,
      CSR_TILE_Y     = 3'd4,
      CSR_TILE_Z     = 3'd5,
      CSR_THREE_COMP = 3'd6
   } csr_index_type;

   // Effective configuration seen by the walker.
   typedef struct packed {
      logic [CFG_W-1:0] cx;
      logic [CFG_W-1:0] cy;
      logic [CFG_W-1:0] cz;
      logic [CFG_W-1:0] tx;
      logic [CFG_W-1:0] ty;
      logic [CFG_W-1:0] tz;
      logic             expand;
      logic [POS_W-1:0] stride_z;       // cells in one xy plane
      logic [POS_W-1:0] stride_y_tile;  // cells in one row of tiles
      logic [POS_W-1:0] stride_z_tile;  // cells in one plane of tiles
      logic             no_tile;        // some tile is larger than the grid
   } cfg_type;

   // One result entry.
   typedef struct packed {
      logic [POS_W-1:0] tiled_position;
      logic [POS_W-1:0] grid_position;
      logic             last;
      logic             valid_res;
   } rsp_type;

   // Clamp a written axis value: zero acts as one, large values as the maximum.
   function automatic logic [CFG_W-1:0] eff_value(input logic [CFG_W-1:0] v,
                                                  input int max_cells);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (int'(v) > max_cells) begin
         r = CFG_W'(max_cells);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tgpg_if.sv =====
// Request and response channel interfaces of the tiled grid permutation generator.
`default_nettype none

interface tgpg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface tgpg_rsp_if import tgpg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] tiled_position;
   logic [POS_W-1:0] grid_position;
   logic             last;
   logic             valid_res;

   modport source (output valid, output tiled_position, output grid_position,
                   output last, output valid_res, input ready);
   modport sink   (input valid, input tiled_position, input grid_position,
                   input last, input valid_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tgpg_walk.sv =====
// Tile-order walk counters with stride-based grid address tracking.
`default_nettype none

module tgpg_walk import tgpg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    clear,
   input  wire logic    step,
   input  wire logic    restart,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   localparam int SPAN_W = CFG_W + 2;

   logic [COMP_W-1:0] comp_ff, comp_in;
   logic [CFG_W-1:0]  ix_ff, ix_in, iy_ff, iy_in, iz_ff, iz_in;
   logic [CFG_W-1:0]  bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic [POS_W-1:0]  p_tz_ff, p_tz_in, p_ty_ff, p_ty_in;
   logic [POS_W-1:0]  p_z_ff, p_z_in, p_y_ff, p_y_in;
   logic [POS_W-1:0]  seq_ff, seq_in;

   // Current state after an optional restart.
   logic [COMP_W-1:0] cur_comp;
   logic [CFG_W-1:0]  cur_ix, cur_iy, cur_iz, cur_bx, cur_by, cur_bz;
   logic [POS_W-1:0]  cur_p_tz, cur_p_ty, cur_p_z, cur_p_y, cur_seq;

   logic              comp_wrap, ix_wrap, iy_wrap, iz_wrap;
   logic              bx_wrap, by_wrap, bz_wrap;
   logic              c_ix, c_iy, c_iz, c_bx, c_by, c_bz, wrap_all;
   logic [SPAN_W-1:0] bx_span, by_span, bz_span;
   logic [POS_W-1:0]  lin, grid, next_ty, next_tz, next_z;

   always_comb begin
      cur_comp = restart ? '0 : comp_ff;
      cur_ix   = restart ? '0 : ix_ff;
      cur_iy   = restart ? '0 : iy_ff;
      cur_iz   = restart ? '0 : iz_ff;
      cur_bx   = restart ? '0 : bx_ff;
      cur_by   = restart ? '0 : by_ff;
      cur_bz   = restart ? '0 : bz_ff;
      cur_p_tz = restart ? '0 : p_tz_ff;
      cur_p_ty = restart ? '0 : p_ty_ff;
      cur_p_z  = restart ? '0 : p_z_ff;
      cur_p_y  = restart ? '0 : p_y_ff;
      cur_seq  = restart ? '0 : seq_ff;
   end

   // Wrap tests. A tile axis wraps when one more whole tile would not fit.
   always_comb begin
      comp_wrap = !cfg.expand || (cur_comp == COMP_LAST);
      ix_wrap   = ({1'b0, cur_ix} + 1'b1) == {1'b0, cfg.tx};
      iy_wrap   = ({1'b0, cur_iy} + 1'b1) == {1'b0, cfg.ty};
      iz_wrap   = ({1'b0, cur_iz} + 1'b1) == {1'b0, cfg.tz};
      bx_span   = SPAN_W'(cur_bx) + SPAN_W'(cfg.tx) + SPAN_W'(cfg.tx);
      by_span   = SPAN_W'(cur_by) + SPAN_W'(cfg.ty) + SPAN_W'(cfg.ty);
      bz_span   = SPAN_W'(cur_bz) + SPAN_W'(cfg.tz) + SPAN_W'(cfg.tz);
      bx_wrap   = bx_span > SPAN_W'(cfg.cx);
      by_wrap   = by_span > SPAN_W'(cfg.cy);
      bz_wrap   = bz_span > SPAN_W'(cfg.cz);
      c_ix      = comp_wrap;
      c_iy      = c_ix && ix_wrap;
      c_iz      = c_iy && iy_wrap;
      c_bx      = c_iz && iz_wrap;
      c_by      = c_bx && bx_wrap;
      c_bz      = c_by && by_wrap;
      wrap_all  = c_bz && bz_wrap;
   end

   // Result for the current entry.
   always_comb begin
      lin  = cur_p_y + POS_W'(cur_bx) + POS_W'(cur_ix);
      grid = cfg.expand ? (lin + {lin[POS_W-2:0], 1'b0} + POS_W'(cur_comp)) : lin;
      if (cfg.no_tile) begin
         result = '0;
      end else begin
         result.tiled_position = cur_seq;
         result.grid_position  = grid;
         result.last           = wrap_all;
         result.valid_res      = 1'b1;
      end
   end

   // Next walk state: the outermost carry decides which bases move.
   always_comb begin
      next_tz = cur_p_tz + cfg.stride_z_tile;
      next_ty = cur_p_ty + cfg.stride_y_tile;
      next_z  = cur_p_z + cfg.stride_z;

      comp_in = '0;
      if (cfg.expand && !comp_wrap) begin
         comp_in = cur_comp + 1'b1;
      end

      ix_in   = cur_ix;
      iy_in   = cur_iy;
      iz_in   = cur_iz;
      bx_in   = cur_bx;
      by_in   = cur_by;
      bz_in   = cur_bz;
      p_tz_in = cur_p_tz;
      p_ty_in = cur_p_ty;
      p_z_in  = cur_p_z;
      p_y_in  = cur_p_y;
      seq_in  = wrap_all ? '0 : cur_seq + 1'b1;

      priority if (wrap_all) begin
         ix_in   = '0;
         iy_in   = '0;
         iz_in   = '0;
         bx_in   = '0;
         by_in   = '0;
         bz_in   = '0;
         p_tz_in = '0;
         p_ty_in = '0;
         p_z_in  = '0;
         p_y_in  = '0;
      end else if (c_bz) begin
         ix_in   = '0;
         iy_in   = '0;
         iz_in   = '0;
         bx_in   = '0;
         by_in   = '0;
         bz_in   = cur_bz + cfg.tz;
         p_tz_in = next_tz;
         p_ty_in = next_tz;
         p_z_in  = next_tz;
         p_y_in  = next_tz;
      end else if (c_by) begin
         ix_in   = '0;
         iy_in   = '0;
         iz_in   = '0;
         bx_in   = '0;
         by_in   = cur_by + cfg.ty;
         p_ty_in = next_ty;
         p_z_in  = next_ty;
         p_y_in  = next_ty;
      end else if (c_bx) begin
         ix_in   = '0;
         iy_in   = '0;
         iz_in   = '0;
         bx_in   = cur_bx + cfg.tx;
         p_z_in  = cur_p_ty;
         p_y_in  = cur_p_ty;
      end else if (c_iz) begin
         ix_in   = '0;
         iy_in   = '0;
         iz_in   = cur_iz + 1'b1;
         p_z_in  = next_z;
         p_y_in  = next_z;
      end else if (c_iy) begin
         ix_in   = '0;
         iy_in   = cur_iy + 1'b1;
         p_y_in  = cur_p_y + POS_W'(cfg.cx);
      end else if (c_ix) begin
         ix_in   = cur_ix + 1'b1;
      end else begin
         ix_in   = cur_ix;
      end
   end

   // State register. With no whole tile a step changes nothing unless it restarts.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         comp_ff <= '0;
         ix_ff   <= '0;
         iy_ff   <= '0;
         iz_ff   <= '0;
         bx_ff   <= '0;
         by_ff   <= '0;
         bz_ff   <= '0;
         p_tz_ff <= '0;
         p_ty_ff <= '0;
         p_z_ff  <= '0;
         p_y_ff  <= '0;
         seq_ff  <= '0;
      end else if (step && cfg.no_tile) begin
         comp_ff <= cur_comp;
         ix_ff   <= cur_ix;
         iy_ff   <= cur_iy;
         iz_ff   <= cur_iz;
         bx_ff   <= cur_bx;
         by_ff   <= cur_by;
         bz_ff   <= cur_bz;
         p_tz_ff <= cur_p_tz;
         p_ty_ff <= cur_p_ty;
         p_z_ff  <= cur_p_z;
         p_y_ff  <= cur_p_y;
         seq_ff  <= cur_seq;
      end else if (step) begin
         comp_ff <= comp_in;
         ix_ff   <= ix_in;
         iy_ff   <= iy_in;
         iz_ff   <= iz_in;
         bx_ff   <= bx_in;
         by_ff   <= by_in;
         bz_ff   <= bz_in;
         p_tz_ff <= p_tz_in;
         p_ty_ff <= p_ty_in;
         p_z_ff  <= p_z_in;
         p_y_ff  <= p_y_in;
         seq_ff  <= seq_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tgpg_skid.sv =====
// Two-entry output buffer that decouples the walker from the response channel.
`default_nettype none

module tgpg_skid import tgpg_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         full,
   output logic         out_valid,
   output rsp_type      out_data,
   input  wire logic    out_ready
);

   logic    main_valid_ff, skid_valid_ff;
   rsp_type main_ff, skid_ff;
   logic    pop;

   assign pop       = main_valid_ff && out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Occupancy: the spare entry fills only when the main entry is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         main_valid_ff <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         main_valid_ff <= 1'b1;
         skid_valid_ff <= main_valid_ff;
      end
   end

   // Payload moves without reset.
   always_ff @(posedge clock) begin
      if (pop && skid_valid_ff) begin
         main_ff <= skid_ff;
      end else if ((pop || !main_valid_ff) && push) begin
         main_ff <= push_data;
      end
      if (!pop && main_valid_ff && push) begin
         skid_ff <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tiled_grid_permutation_generator.sv =====
// Top level of the tiled grid permutation generator: registers, strides, channels.
//
// Each request transfer yields exactly one response transfer, and a new request
// is taken every cycle while the two-entry output buffer has room and no write
// is in progress or settling; the result is registered in the output buffer,
// which keeps order. The walk keeps tile and cell counters with base addresses
// that advance by stride adds, so one entry is produced per cycle while requests
// are taken. The strides come from registered products of the axis registers:
// after any register write, request ready stays low while the plane size and the
// tile-plane size are recomputed. A write restarts the walk at its first entry.
`default_nettype none

module tiled_grid_permutation_generator import tgpg_pkg::*; #(
   parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   tgpg_req_if.sink              req_ch,
   tgpg_rsp_if.source            rsp_ch,
   input  wire logic             csr_write,
   input  wire logic [2:0]       csr_index,
   input  wire logic [CFG_W-1:0] csr_data
);

   logic [CFG_W-1:0] cx_ff, cy_ff, cz_ff, tx_ff, ty_ff, tz_ff;
   logic             expand_ff;
   logic [POS_W-1:0] sz_ff, sty_ff, stz_ff;
   logic             no_tile_ff;
   logic [1:0]       settle_ff;
   logic [CFG_W-1:0] wr_value;
   logic             wr_hit;
   logic             step;
   logic             buf_full;
   cfg_type          cfg;
   rsp_type          walk_result;
   rsp_type          out_data;

   assign wr_value = eff_value(csr_data, MAX_CELLS_PER_AXIS);

   // Writes to an index past the register list are ignored.
   always_comb begin
      unique case (csr_index_type'(csr_index))
         CSR_CELLS_X, CSR_CELLS_Y, CSR_CELLS_Z, CSR_TILE_X, CSR_TILE_Y, CSR_TILE_Z,
         CSR_THREE_COMP: wr_hit = csr_write;
         default:        wr_hit = 1'b0;
      endcase
   end

   // Configuration registers hold the clamped axis values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= CFG_W'(1);
         cy_ff     <= CFG_W'(1);
         cz_ff     <= CFG_W'(1);
         tx_ff     <= CFG_W'(1);
         ty_ff     <= CFG_W'(1);
         tz_ff     <= CFG_W'(1);
         expand_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_CELLS_X:    cx_ff     <= wr_value;
            CSR_CELLS_Y:    cy_ff     <= wr_value;
            CSR_CELLS_Z:    cz_ff     <= wr_value;
            CSR_TILE_X:     tx_ff     <= wr_value;
            CSR_TILE_Y:     ty_ff     <= wr_value;
            CSR_TILE_Z:     tz_ff     <= wr_value;
            CSR_THREE_COMP: expand_ff <= csr_data[0];
            default:        expand_ff <= expand_ff;
         endcase
      end
   end

   // Stride products; the tile-plane stride multiplies the registered plane size.
   always_ff @(posedge clock) begin
      sz_ff      <= POS_W'(cx_ff * cy_ff);
      sty_ff     <= POS_W'(cx_ff * ty_ff);
      stz_ff     <= POS_W'(sz_ff * tz_ff);
      no_tile_ff <= (tx_ff > cx_ff) || (ty_ff > cy_ff) || (tz_ff > cz_ff);
   end

   // Hold off requests until the products reflect the latest write.
   always_ff @(posedge clock) begin
      if (reset || wr_hit) begin
         settle_ff <= SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - 1'b1;
      end
   end

   always_comb begin
      cfg.cx            = cx_ff;
      cfg.cy            = cy_ff;
      cfg.cz            = cz_ff;
      cfg.tx            = tx_ff;
      cfg.ty            = ty_ff;
      cfg.tz            = tz_ff;
      cfg.expand        = expand_ff;
      cfg.stride_z      = sz_ff;
      cfg.stride_y_tile = sty_ff;
      cfg.stride_z_tile = stz_ff;
      cfg.no_tile       = no_tile_ff;
   end

   assign req_ch.ready = (settle_ff == '0) && !csr_write && !buf_full;
   assign step         = req_ch.valid && req_ch.ready;

   tgpg_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .clear   (wr_hit),
      .step    (step),
      .restart (req_ch.restart),
      .cfg     (cfg),
      .result  (walk_result)
   );

   tgpg_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .push_data (walk_result),
      .full      (buf_full),
      .out_valid (rsp_ch.valid),
      .out_data  (out_data),
      .out_ready (rsp_ch.ready)
   );

   assign rsp_ch.tiled_position = out_data.tiled_position;
   assign rsp_ch.grid_position  = out_data.grid_position;
   assign rsp_ch.last           = out_data.last;
   assign rsp_ch.valid_res      = out_data.valid_res;

   // A request transfer always leaves a result waiting on the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> rsp_ch.valid)
      else $error("accepted request left no pending response");

   // No request transfer while the strides settle after a register write.
   a_settle_first: assert property (@(posedge clock) disable iff (reset)
      wr_hit |=> !req_ch.ready)
      else $error("request taken while strides settle");

   a_settle_second: assert property (@(posedge clock) disable iff (reset)
      wr_hit |=> ##1 !req_ch.ready)
      else $error("request taken while strides settle");

   // An entry without a whole tile carries all-zero fields.
   a_no_tile_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.valid_res) |->
      (rsp_ch.tiled_position == '0 && rsp_ch.grid_position == '0 && !rsp_ch.last))
      else $error("invalid entry with nonzero fields");

endmodule

`default_nettype wire
